@@ rtl/rcc_pkg.sv @@
// Shared types and constants for the ranked-choice compatibility block.
package rcc_pkg;

   localparam int MAX_TYPES      = 8;
   localparam int OPTION_COUNT   = 8;
   localparam int RANK_WIDTH     = 4;
   localparam int RANKS_WIDTH    = OPTION_COUNT * RANK_WIDTH;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REQ_DATA_WIDTH = 16;
   localparam int RSP_DATA_WIDTH = 16;

   typedef logic [RANK_WIDTH-1:0]    rank_type;
   typedef logic [RANKS_WIDTH-1:0]   ranks_type;
   typedef logic [2:0]               option_type;
   typedef logic [6:0]               offered_type;
   typedef logic [MAX_TYPES-1:0]     type_mask_type;
   typedef logic [3:0]               type_count_type;

   // One period as it travels from the input register to the per-type checks.
   typedef struct packed {
      option_type  chosen_product;
      offered_type offered_mask;
   } period_type;

endpackage

@@ rtl/ranked_choice_compatibility.sv @@
// Top level of the ranked-choice compatibility block with its register port.
//
// Each request item carries the products on offer in one period and the option
// chosen (0 for no purchase); the response item gives the mask of customer types
// whose configured ranking agrees with that choice, and how many they are. One
// item is taken every clock cycle while req_tready is high. An item accepted at a
// clock edge enters the input register, and its result is loaded into the output
// register once that register is free, which then presents it. While a response
// is stalled the input register still takes one further item. The rank registers
// are written over the csr_ port and should only be changed while no item is in
// flight.
module ranked_choice_compatibility #(
   parameter int NUM_TYPES    = 8,
   parameter int NUM_PRODUCTS = 7
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [6:0] offered_mask, [9:7] chosen_product, [15:10] zero
   input  logic [rcc_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [7:0] compatible_mask, [11:8] compatible_count, [15:12] zero
   output logic [rcc_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rcc_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [rcc_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [rcc_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   rcc_pkg::ranks_type      ranks_ff [NUM_TYPES];
   logic [2:0]              csr_index;
   logic                    csr_write;

   logic                    stage_valid_ff, stage_valid_in;
   rcc_pkg::period_type     stage_period_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rcc_pkg::type_mask_type  rsp_mask_ff, rsp_mask_in;
   rcc_pkg::type_count_type rsp_count_ff, rsp_count_in;

   logic                    rsp_free;
   logic                    req_accept;
   logic [NUM_TYPES-1:0]    type_ok;

   // Register port: no wait states, word-addressed rank registers.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TYPES; i++) begin
            ranks_ff[i] <= '0;
         end
      end else if (csr_write) begin
         for (int i = 0; i < NUM_TYPES; i++) begin
            if (csr_index == 3'(i)) begin
               ranks_ff[i] <= csr_pwdata;
            end
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      for (int i = 0; i < NUM_TYPES; i++) begin
         if (csr_index == 3'(i)) begin
            csr_prdata = ranks_ff[i];
         end
      end
   end

   // Two-register pipeline; the input register empties whenever the output frees.
   assign rsp_free       = !rsp_valid_ff || rsp_tready;
   assign req_tready     = !stage_valid_ff || rsp_free;
   assign req_accept     = req_tvalid && req_tready;
   assign stage_valid_in = req_accept || (stage_valid_ff && !rsp_free);
   assign rsp_valid_in   = rsp_free ? stage_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_period_ff.offered_mask   <= req_tdata[6:0];
         stage_period_ff.chosen_product <= req_tdata[9:7];
      end
      if (rsp_free && stage_valid_ff) begin
         rsp_mask_ff  <= rsp_mask_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   for (genvar t = 0; t < NUM_TYPES; t++) begin : g_type
      rcc_type_check #(
         .NUM_PRODUCTS (NUM_PRODUCTS)
      ) u_check (
         .ranks      (ranks_ff[t]),
         .period     (stage_period_ff),
         .compatible (type_ok[t])
      );
   end

   always_comb begin
      rsp_mask_in  = '0;
      rsp_count_in = '0;
      for (int i = 0; i < NUM_TYPES; i++) begin
         rsp_mask_in[i] = type_ok[i];
         rsp_count_in   = rsp_count_in + rcc_pkg::type_count_type'(type_ok[i]);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_count_ff, rsp_mask_ff};

   // The count always agrees with the mask it travels with.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (32'(rsp_count_ff) == 32'($countones(rsp_mask_ff))))
      else $error("compatible_count does not match compatible_mask");

   // Types beyond the configured number are never reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((16'(rsp_mask_ff) >> NUM_TYPES) == 16'd0))
      else $error("mask bit set for an unconfigured type");

   // A waiting item in the input register is not dropped while the output stalls.
   assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !rsp_free) |=> (stage_valid_ff && $stable(stage_period_ff)))
      else $error("input register lost an item during a stall");

   // An item in the input register reaches the output once the output frees.
   assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && rsp_free) |=> rsp_valid_ff)
      else $error("item did not advance to the output register");

endmodule

@@ rtl/rcc_type_check.sv @@
// Compatibility check of one customer type against one period.
module rcc_type_check #(
   parameter int NUM_PRODUCTS = 7
) (
   input  rcc_pkg::ranks_type  ranks,
   input  rcc_pkg::period_type period,
   output logic                compatible
);

   rcc_pkg::rank_type chosen_rank;
   rcc_pkg::rank_type option_rank [rcc_pkg::OPTION_COUNT];
   logic [NUM_PRODUCTS-1:0] beaten;

   always_comb begin
      for (int k = 0; k < rcc_pkg::OPTION_COUNT; k++) begin
         option_rank[k] = ranks[k*rcc_pkg::RANK_WIDTH +: rcc_pkg::RANK_WIDTH];
      end
   end

   assign chosen_rank = option_rank[period.chosen_product];

   // A product on offer other than the chosen one must not rank strictly better.
   always_comb begin
      for (int k = 1; k <= NUM_PRODUCTS; k++) begin
         beaten[k-1] = period.offered_mask[k-1]
                       && (period.chosen_product != rcc_pkg::option_type'(k))
                       && (option_rank[k] < chosen_rank);
      end
   end

   assign compatible = !(|beaten) && !(option_rank[0] < chosen_rank);

endmodule

@@ sim/tb_ranked_choice_compatibility.sv @@
// Self-checking testbench for the ranked-choice compatibility block.
module tb_ranked_choice_compatibility;

   localparam int NUM_TYPES       = 8;
   localparam int NUM_PRODUCTS    = 7;
   localparam int SETTLE_CYCLES   = 4;
   localparam int IDLE_LIMIT      = 400;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 48;
   localparam int MAX_REPORTS     = 10;

   // Directed periods packed as {chosen_product, offered_mask}.
   localparam logic [9:0] DIRECTED_PERIODS [0:17] = '{
      {3'd0, 7'h00}, {3'd0, 7'h7f}, {3'd7, 7'h7f}, {3'd7, 7'h00},
      {3'd1, 7'h7f}, {3'd1, 7'h01}, {3'd1, 7'h02}, {3'd7, 7'h40},
      {3'd7, 7'h3f}, {3'd2, 7'h7f}, {3'd3, 7'h7f}, {3'd4, 7'h7f},
      {3'd5, 7'h7f}, {3'd6, 7'h7f}, {3'd3, 7'h55}, {3'd4, 7'h2a},
      {3'd3, 7'h04}, {3'd3, 7'h08}
   };

   // Ties everywhere, all ones, ranks above eight, non-viable options and a
   // chosen product that can win without being offered.
   localparam rcc_pkg::ranks_type DIRECTED_RANKS [0:7] = '{
      32'h0000_0000, 32'hffff_ffff, 32'h7654_3210, 32'h0123_4567,
      32'h8888_1238, 32'hf9a0_b1c2, 32'h3fc5_28e1, 32'h0fff_ffff
   };

   typedef struct packed {
      rcc_pkg::type_mask_type  mask;
      rcc_pkg::type_count_type count;
   } compat_result_type;

   class compat_ledger;
      rcc_pkg::ranks_type rank_table [rcc_pkg::MAX_TYPES];
      compat_result_type  expected_results [$];
      int                 failures;

      function new();
         foreach (rank_table[t]) rank_table[t] = '0;
         failures = 0;
      endfunction

      function void set_ranks(int index, rcc_pkg::ranks_type value);
         rank_table[index] = value;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // Works out which customer types agree with the period's choice.
      function void note_period(rcc_pkg::offered_type offered,
                                rcc_pkg::option_type chosen);
         compat_result_type  result;
         rcc_pkg::rank_type  chosen_rank;
         logic               fits;
         result.mask  = '0;
         result.count = '0;
         for (int t = 0; t < NUM_TYPES; t++) begin
            chosen_rank =
               rank_table[t][int'(chosen) * rcc_pkg::RANK_WIDTH +: rcc_pkg::RANK_WIDTH];
            fits = !(rank_table[t][rcc_pkg::RANK_WIDTH-1:0] < chosen_rank);
            for (int k = 1; k <= NUM_PRODUCTS; k++) begin
               if (offered[k-1] && k != int'(chosen) &&
                   rank_table[t][k * rcc_pkg::RANK_WIDTH +: rcc_pkg::RANK_WIDTH]
                      < chosen_rank)
                  fits = 1'b0;
            end
            if (fits) begin
               result.mask[t] = 1'b1;
               result.count   = result.count + 1'b1;
            end
         end
         expected_results.push_back(result);
      endfunction

      function void check_result(rcc_pkg::type_mask_type mask,
                                 rcc_pkg::type_count_type count);
         compat_result_type want;
         if (expected_results.size() == 0) begin
            if (failures < MAX_REPORTS)
               $display("unexpected result: mask %02h count %0d", mask, count);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         if (want.mask !== mask || want.count !== count) begin
            if (failures < MAX_REPORTS)
               $display("mismatch: expected mask %02h count %0d, got mask %02h count %0d",
                        want.mask, want.count, mask, count);
            failures++;
         end
      endfunction
   endclass

   logic                               clock       = 1'b0;
   logic                               reset       = 1'b1;
   logic                               req_tvalid  = 1'b0;
   logic                               req_tready;
   logic [rcc_pkg::REQ_DATA_WIDTH-1:0] req_tdata   = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready  = 1'b0;
   logic [rcc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                               csr_psel    = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite  = 1'b0;
   logic [rcc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [rcc_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [rcc_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                               csr_pready;

   compat_ledger compat_book = new();
   int           idle_cycles = 0;
   int           req_calm    = 0;
   int           rsp_calm    = 0;

   ranked_choice_compatibility #(
      .NUM_TYPES    (NUM_TYPES),
      .NUM_PRODUCTS (NUM_PRODUCTS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly random gaps, broken now and then by a run of back-to-back items.
   function automatic int draw_gap(ref int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   task automatic send_period(input rcc_pkg::offered_type offered,
                              input rcc_pkg::option_type chosen);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, chosen, offered};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_ranks(input int index, input rcc_pkg::ranks_type value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= rcc_pkg::CSR_ADDR_WIDTH'(index * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      compat_book.set_ranks(index, value);
      @(posedge clock);
   endtask

   // Drop the request, let the last item be noted, then wait until no result is pending.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (compat_book.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(rsp_calm);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            compat_book.check_result(rsp_tdata[7:0], rsp_tdata[11:8]);
         if (req_tvalid && req_tready)
            compat_book.note_period(req_tdata[6:0], req_tdata[9:7]);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) ||
             (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      rcc_pkg::ranks_type   regval;
      rcc_pkg::offered_type offered;
      rcc_pkg::option_type  chosen;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With every rank at zero each type ties and so agrees with any choice.
      send_period(7'h7f, 3'd0);
      send_period(7'h00, 3'd7);
      send_period(7'h55, 3'd5);
      drain_pipeline();

      for (int t = 0; t < rcc_pkg::MAX_TYPES; t++) write_ranks(t, DIRECTED_RANKS[t]);
      foreach (DIRECTED_PERIODS[n])
         send_period(DIRECTED_PERIODS[n][6:0], DIRECTED_PERIODS[n][9:7]);
      drain_pipeline();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         for (int t = 0; t < rcc_pkg::MAX_TYPES; t++) begin
            case ($urandom_range(0, 3))
               0: begin
                  regval = $urandom();
               end
               1, 2: begin
                  for (int k = 0; k < rcc_pkg::OPTION_COUNT; k++)
                     regval[k * rcc_pkg::RANK_WIDTH +: rcc_pkg::RANK_WIDTH] =
                        ($urandom_range(0, 3) == 0) ? 4'd8 : 4'($urandom_range(0, 7));
               end
               default: begin
                  case ($urandom_range(0, 3))
                     0: regval = 32'h0000_0000;
                     1: regval = 32'hffff_ffff;
                     2: regval = 32'h8888_8888;
                     default: regval = 32'h0f0f_0f0f;
                  endcase
               end
            endcase
            write_ranks(t, regval);
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 2) == 0)
               offered = 7'(1 << $urandom_range(0, 6)) | 7'(1 << $urandom_range(0, 6));
            else
               offered = 7'($urandom());
            if (offered != '0 && $urandom_range(0, 1) == 1) begin
               do chosen = 3'($urandom_range(1, 7));
               while (!offered[chosen - 1]);
            end else begin
               chosen = 3'($urandom_range(0, 7));
            end
            send_period(offered, chosen);
         end
         drain_pipeline();
      end

      if (compat_book.failures == 0 && compat_book.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
